// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Request codes, transaction payload structs and the per-cell command group.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DATA_W        = 32;
	localparam int FILL_W        = 5;
	localparam int DEPTH_DEFAULT = 16;

	// request codes
	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} req_kind_t;

	// request transaction
	typedef struct packed {
		req_kind_t                 req_type;
		logic signed [DATA_W-1:0]  push_value;
	} dq_req_t;

	// response transaction
	typedef struct packed {
		logic                      status;
		logic signed [DATA_W-1:0]  pop_value;
		logic                      is_empty;
		logic [FILL_W-1:0]         fill_count;
	} dq_rsp_t;

	// command broadcast to every cell, already qualified by acceptance
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} dq_cmd_t;

endpackage

// File: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit signed values
// A row of DEPTH cells keeps the elements packed from cell 0 (front) upward.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------
//  request | req_valid | req_stall | req (req_type, push_value)
//  reply   | rsp_valid | rsp_stall | rsp (status, pop_value, is_empty,
//          |           |           |      fill_count)
//
// A request is served at the edge that accepts it: the cell row shifts or
// loads and the reply is registered at that same edge, so one request
// per cycle is taken while replies are drained. The tail is found by each
// cell against its neighbor, and the popped back value is a one-hot OR over
// the row. Reset empties the row and the reply register at once. A stalled
// reply holds the request side off until it is taken.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dq_pkg::dq_req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output dq_pkg::dq_rsp_t rsp
);
	import dq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  is_push;
	logic                  refused;
	dq_cmd_t               cmd;
	logic [DEPTH-1:0]      cell_valid;
	logic [DATA_W-1:0]     cell_data [DEPTH];
	logic [DATA_W-1:0]     cell_tail [DEPTH];
	logic [DATA_W-1:0]     tail_value;
	logic [DATA_W-1:0]     popped;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;
	logic                  rsp_valid_q;
	dq_rsp_t               rsp_q;

	// handshake
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign full  = cell_valid[DEPTH-1];
	assign empty = !cell_valid[0];

	// request decode
	always_comb begin
		cmd = '0;
		unique case (req.req_type)
			REQ_PUSH_FRONT: cmd.push_front = 1'b1;
			REQ_PUSH_BACK:  cmd.push_back  = 1'b1;
			REQ_POP_FRONT:  cmd.pop_front  = 1'b1;
			REQ_POP_BACK:   cmd.pop_back   = 1'b1;
			default:        cmd = '0;
		endcase
		is_push = cmd.push_front || cmd.push_back;
		refused = is_push ? full : empty;
		if (!accept || refused) begin
			cmd = '0;
		end
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              prev_valid;
		logic [DATA_W-1:0] prev_data;
		logic              next_valid;
		logic [DATA_W-1:0] next_data;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
			assign prev_data  = req.push_value;
		end else begin : g_mid
			assign prev_valid = cell_valid[i-1];
			assign prev_data  = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_data  = '0;
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_data  = cell_data[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prev_valid),
			.prev_data  (prev_data),
			.next_valid (next_valid),
			.next_data  (next_data),
			.push_value (req.push_value),
			.valid      (cell_valid[i]),
			.data       (cell_data[i]),
			.tail_data  (cell_tail[i])
		);
	end

	// gather the tail element (at most one cell drives nonzero)
	always_comb begin
		tail_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_value = tail_value | cell_tail[i];
		end
	end

	// popped value and next count
	always_comb begin
		popped     = '0;
		count_next = count_q;
		if (cmd.pop_front) begin
			popped     = cell_data[0];
			count_next = count_q - CNT_W'(1);
		end else if (cmd.pop_back) begin
			popped     = tail_value;
			count_next = count_q - CNT_W'(1);
		end else if (cmd.push_front || cmd.push_back) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= refused;
			rsp_q.pop_value  <= popped;
			rsp_q.is_empty   <= (count_next == '0);
			rsp_q.fill_count <= FILL_W'(count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one slot of the deque cell row
// Holds one element and its occupancy bit; shifts toward either neighbor,
// takes a pushed value when it is the first free slot, and drops out when
// it is the tail on a pop from the back.
// ----------------------------------------------------------------------------
module dq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dq_pkg::dq_cmd_t             cmd,
	input  logic                        prev_valid,
	input  logic [dq_pkg::DATA_W-1:0]   prev_data,
	input  logic                        next_valid,
	input  logic [dq_pkg::DATA_W-1:0]   next_data,
	input  logic [dq_pkg::DATA_W-1:0]   push_value,
	output logic                        valid,
	output logic [dq_pkg::DATA_W-1:0]   data,
	output logic [dq_pkg::DATA_W-1:0]   tail_data
);
	import dq_pkg::*;

	logic              valid_q;
	logic [DATA_W-1:0] data_q;
	logic              is_tail;

	assign is_tail = valid_q && !next_valid;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push_front) begin
			valid_q <= prev_valid;
		end else if (cmd.pop_front) begin
			valid_q <= next_valid;
		end else if (cmd.push_back && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end else if (cmd.pop_back && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	// element data
	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= prev_data;
		end else if (cmd.pop_front) begin
			data_q <= next_data;
		end else if (cmd.push_back && !valid_q && prev_valid) begin
			data_q <= push_value;
		end
	end

	assign valid     = valid_q;
	assign data      = data_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

// File: sim/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker: scoreboard for the double-ended queue
// Watches both channels, keeps its own ring model of the deque, predicts one
// reply per accepted request and compares every accepted reply field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module dq_checker #(
	parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  dq_pkg::dq_req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  dq_pkg::dq_rsp_t rsp,
	output int              fail_count,
	output int              pending
);
	import dq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	// model state: ring cells, front position and element count
	logic signed [DATA_W-1:0] cells [DEPTH];
	logic [IDX_W-1:0]         front;
	logic [FILL_W-1:0]        held;

	dq_rsp_t expected_replies [$];
	int      mismatches;

	// apply one request to the model and return the reply it should give
	function automatic dq_rsp_t deque_apply(dq_req_t r);
		dq_rsp_t          o;
		logic [IDX_W-1:0] slot;
		o = '0;
		case (r.req_type)
			REQ_PUSH_FRONT: begin
				if (held == DEPTH) begin
					o.status = 1'b1;
				end else begin
					front        = front - 1'b1;
					cells[front] = r.push_value;
					held         = held + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (held == DEPTH) begin
					o.status = 1'b1;
				end else begin
					slot        = front + held[IDX_W-1:0];
					cells[slot] = r.push_value;
					held        = held + 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (held == 0) begin
					o.status = 1'b1;
				end else begin
					o.pop_value = cells[front];
					front       = front + 1'b1;
					held        = held - 1'b1;
				end
			end
			default: begin
				if (held == 0) begin
					o.status = 1'b1;
				end else begin
					slot        = front + held[IDX_W-1:0] - 1'b1;
					o.pop_value = cells[slot];
					held        = held - 1'b1;
				end
			end
		endcase
		o.is_empty   = (held == 0);
		o.fill_count = held;
		return o;
	endfunction

	// reply check first (it belongs to an older request), then prediction
	always @(posedge clk or negedge arst_n) begin
		dq_rsp_t want;
		if (!arst_n) begin
			front      = '0;
			held       = '0;
			mismatches = 0;
			expected_replies.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					$error("reply with no request outstanding");
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.pop_value !== want.pop_value) begin
						$error("pop_value: expected %0d, got %0d",
							want.pop_value, rsp.pop_value);
						mismatches++;
					end
					if (rsp.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d",
							want.is_empty, rsp.is_empty);
						mismatches++;
					end
					if (rsp.fill_count !== want.fill_count) begin
						$error("fill_count: expected %0d, got %0d",
							want.fill_count, rsp.fill_count);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_replies.push_back(deque_apply(req));
			fail_count <= mismatches;
			pending    <= expected_replies.size();
		end
	end

endmodule

// File: sim/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue: stimulus and verdict for the double-ended queue
// Directed corner cases (empty and full refusals, extreme values), then
// random request streams biased toward filling or draining, with bursty
// requests, a patterned reply stall and one long reply hold-off.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	import dq_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_LIMIT   = 2000;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	dq_req_t req       = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	dq_rsp_t rsp;

	int   fail_count;
	int   pending;
	logic hold_go   = 1'b0;
	logic hold_done = 1'b0;
	int   idle_cycles = 0;

	always #6 clk = ~clk;

	double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	dq_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// present one request and hold it until the transaction is taken
	task automatic offer(input req_kind_t kind, input logic signed [DATA_W-1:0] value);
		req       <= '{req_type: kind, push_value: value};
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic pause_sender(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// reply side: one long hold-off on request, otherwise a changing pattern
	initial begin
		int hold_left;
		int seg_left;
		int mode;
		hold_left = 0;
		seg_left  = 0;
		mode      = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (mode)
					0:       rsp_stall <= 1'b0;
					1:       rsp_stall <= ($urandom_range(0, 3) == 0);
					2:       rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= ~rsp_stall;
				endcase
			end
		end
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int  items;
		int  burst_left;
		int  phase_left;
		int  push_bias;
		bit  gapless;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty refusals, extremes through both ends
		offer(REQ_POP_FRONT, 32'sh1234_5678);
		offer(REQ_POP_BACK, -1);
		offer(REQ_PUSH_FRONT, 32'sh8000_0000);
		offer(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
		offer(REQ_POP_FRONT, '0);
		offer(REQ_POP_BACK, '0);
		// fill from both ends, then push on full at each end
		for (int i = 0; i < DEPTH_DEFAULT; i++)
			offer(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
				i[1] ? (32'sh5555_5555 ^ i) : (32'shAAAA_AAAA ^ i));
		offer(REQ_PUSH_FRONT, 32'sd1);
		offer(REQ_PUSH_BACK, 32'sd2);

		// random phases biased toward filling, draining or balanced
		items      = 0;
		burst_left = $urandom_range(1, 24);
		phase_left = 0;
		push_bias  = 50;
		gapless    = 1'b0;
		while (items < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0:       push_bias = 85;
					1:       push_bias = 15;
					default: push_bias = 50;
				endcase
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			if (items == 300)
				hold_go <= 1'b1;
			if ($urandom_range(0, 99) < push_bias)
				offer($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
			else
				offer($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_value());
			items++;
			// wait once in the middle of the run until no reply is outstanding
			// (the count seen at an edge does not yet include that edge's transaction)
			if (items == 600) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			burst_left--;
			if (burst_left == 0) begin
				if (!gapless)
					pause_sender($urandom_range(1, 6));
				gapless    = ($urandom_range(0, 3) == 0);
				burst_left = $urandom_range(1, 24);
			end
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
